FILE: hw/rtl/ppd_pkg.sv
// Shared constants, state encoding and control types for the pairwise p-distance block.
package ppd_pkg;

  localparam int FIELD_W = 17;
  localparam int FRAC_W = 16;
  localparam int SYM_W = 8;
  localparam int FIELD_MAX = 131071;
  localparam int MAX_COLUMNS_DEF = 65536;
  localparam int STEP_W = $clog2(FRAC_W);

  localparam logic [SYM_W-1:0] GAP_BYTE = 8'h2D;
  localparam logic [FIELD_W-1:0] ONE_Q16 = FIELD_W'(65536);

  typedef enum logic [1:0] {
    ST_COUNT,
    ST_LOAD,
    ST_ITER,
    ST_WRITE
  } ppd_state_t;

  typedef struct packed {
    logic cnt_en;
    logic div_load;
    logic div_step;
    logic out_load;
  } ppd_cmd_t;

  typedef struct packed {
    logic div_trivial;
    logic step_last;
    logic out_free;
  } ppd_status_t;

endpackage

FILE: hw/rtl/ppd_ctrl.sv
// Controller state machine: column intake, division sequencing and result hand-off.
module ppd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                last,
  output logic                in_stall,
  input  ppd_pkg::ppd_status_t status,
  output ppd_pkg::ppd_cmd_t    cmd
);
  import ppd_pkg::*;

  ppd_state_t state;
  ppd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_COUNT: begin
        in_stall = 1'b0;
        cmd.cnt_en = in_valid;
        if (in_valid && last) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        state_next = status.div_trivial ? ST_WRITE : ST_ITER;
      end
      ST_ITER: begin
        cmd.div_step = 1'b1;
        if (status.step_last) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_COUNT;
        end
      end
      default: begin
        state_next = ST_COUNT;
      end
    endcase
  end

endmodule

FILE: hw/rtl/ppd_datapath.sv
// Datapath: column counters, shift-subtract divider and result register.
module ppd_datapath #(
  parameter int MAX_COLUMNS = ppd_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ppd_pkg::ppd_cmd_t                cmd,
  output ppd_pkg::ppd_status_t             status,
  input  logic [ppd_pkg::SYM_W-1:0]        sym_a,
  input  logic [ppd_pkg::SYM_W-1:0]        sym_b,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ppd_pkg::FIELD_W-1:0]      distance,
  output logic [ppd_pkg::FIELD_W-1:0]      compared,
  output logic [ppd_pkg::FIELD_W-1:0]      mismatches,
  output logic                            no_overlap
);
  import ppd_pkg::*;

  localparam int LIMIT_INT = (MAX_COLUMNS < FIELD_MAX) ? MAX_COLUMNS : FIELD_MAX;
  localparam logic [FIELD_W-1:0] COUNT_LIMIT = FIELD_W'(LIMIT_INT);

  logic [FIELD_W-1:0] compared_count;
  logic [FIELD_W-1:0] mismatch_count;
  logic [FIELD_W-1:0] rem;
  logic [FIELD_W-1:0] quo;
  logic [STEP_W-1:0]  step;
  logic               qualify;
  logic [FIELD_W:0]   rem2;
  logic               ge;

  assign qualify = (sym_a != GAP_BYTE) && (sym_b != GAP_BYTE) && (compared_count < COUNT_LIMIT);
  assign rem2 = {rem, 1'b0};
  assign ge = rem2 >= {1'b0, compared_count};

  assign status.div_trivial = (mismatch_count == compared_count);
  assign status.step_last = (step == '0);
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      compared_count <= '0;
      mismatch_count <= '0;
    end else if (cmd.out_load) begin
      compared_count <= '0;
      mismatch_count <= '0;
    end else if (cmd.cnt_en && qualify) begin
      compared_count <= compared_count + FIELD_W'(1);
      if (sym_a != sym_b) begin
        mismatch_count <= mismatch_count + FIELD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= mismatch_count;
      quo <= status.div_trivial ? ONE_Q16 : '0;
      step <= STEP_W'(FRAC_W - 1);
    end else if (cmd.div_step) begin
      if (ge) begin
        rem <= FIELD_W'(rem2 - {1'b0, compared_count});
      end else begin
        rem <= rem2[FIELD_W-1:0];
      end
      quo <= {quo[FIELD_W-2:0], ge};
      step <= step - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      distance <= quo;
      compared <= compared_count;
      mismatches <= mismatch_count;
      no_overlap <= (compared_count == '0);
    end
  end

endmodule

FILE: hw/rtl/pairwise_p_distance.sv
// Top level of the pairwise p-distance block.
// Columns are taken one a beat while the pair is being counted; gap columns and columns past
// the count limit leave the counters alone. The beat marked last closes the pair: intake then
// stops for the load and write-back states when the mismatch and compared counts are equal
// (including no overlap), otherwise also through the 16 steps of the shift-subtract divider
// that forms the Q1.16 quotient one bit a cycle. A finished result sits in the output
// register, so intake of the next pair resumes while it waits to be taken; the block holds
// only if a second result is ready before the first has gone.
module pairwise_p_distance #(
  parameter int MAX_COLUMNS = ppd_pkg::MAX_COLUMNS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ppd_pkg::SYM_W-1:0]  sym_a,
  input  logic [ppd_pkg::SYM_W-1:0]  sym_b,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ppd_pkg::FIELD_W-1:0] distance,
  output logic [ppd_pkg::FIELD_W-1:0] compared,
  output logic [ppd_pkg::FIELD_W-1:0] mismatches,
  output logic                       no_overlap
);
  import ppd_pkg::*;

  ppd_cmd_t    cmd;
  ppd_status_t status;

  ppd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ppd_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .sym_a      (sym_a),
    .sym_b      (sym_b),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .distance   (distance),
    .compared   (compared),
    .mismatches (mismatches),
    .no_overlap (no_overlap)
  );

endmodule

FILE: hw/rtl/ppd_checker.sv
// Port-level checker for the pairwise p-distance block, with its bind.
module ppd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       last,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ppd_pkg::FIELD_W-1:0] distance,
  input logic [ppd_pkg::FIELD_W-1:0] compared,
  input logic [ppd_pkg::FIELD_W-1:0] mismatches,
  input logic                       no_overlap
);
  import ppd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance) && $stable(compared)
      && $stable(mismatches) && $stable(no_overlap))
    else $error("stalled result beat changed");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_overlap |-> distance == ONE_Q16 && compared == '0 && mismatches == '0)
    else $error("no-overlap result malformed");

  a_ratio: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mismatches <= compared && distance <= ONE_Q16
      && (no_overlap || compared != '0))
    else $error("result counts inconsistent");

  a_close_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last |=> in_stall)
    else $error("intake not held after closing beat");

endmodule

bind pairwise_p_distance ppd_checker u_ppd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .last       (last),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .distance   (distance),
  .compared   (compared),
  .mismatches (mismatches),
  .no_overlap (no_overlap)
);
